// ===== hdl/mer_pkg.sv =====
package mer_pkg;

  // width of the signed column and row results
  localparam int OUT_W = 14;

  // command field of an input transaction
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_SQ_RY,
    OP_SLOPE,
    OP_INIT,
    OP_STEP,
    OP_DEC_UPD,
    OP_E2_XX,
    OP_E2_RY2,
    OP_E2_YM1,
    OP_E2_RX2,
    OP_E2_RXRY,
    OP_E2_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   region2;
    logic   out_load;
    logic   out_null;
    logic   last;
  } dp_cmd_t;

  typedef struct packed {
    logic sx_lt_sy;
    logic y_pos;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== hdl/mer_in_if.sv =====
interface mer_in_if #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic                   cmd;
  logic [COORD_BITS-1:0]  center_x;
  logic [COORD_BITS-1:0]  center_y;
  logic [RADIUS_BITS-1:0] radius_x;
  logic [RADIUS_BITS-1:0] radius_y;
  logic                   fill_mode;

  modport source (
    output valid, cmd, center_x, center_y, radius_x, radius_y, fill_mode,
    input  ready
  );

  modport sink (
    input  valid, cmd, center_x, center_y, radius_x, radius_y, fill_mode,
    output ready
  );
endinterface

// ===== hdl/mer_out_if.sv =====
interface mer_out_if #(
  parameter int RADIUS_BITS = 10
);
  import mer_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    valid_res;
  logic                    last;
  logic                    is_fill;
  logic signed [OUT_W-1:0] left_col;
  logic signed [OUT_W-1:0] right_col;
  logic signed [OUT_W-1:0] lower_row;
  logic signed [OUT_W-1:0] upper_row;
  logic [RADIUS_BITS-1:0]  step_x;
  logic [RADIUS_BITS-1:0]  step_y;

  modport source (
    output valid, valid_res, last, is_fill, left_col, right_col, lower_row, upper_row,
           step_x, step_y,
    input  ready
  );

  modport sink (
    input  valid, valid_res, last, is_fill, left_col, right_col, lower_row, upper_row,
           step_x, step_y,
    output ready
  );
endinterface

// ===== hdl/mer_ctrl.sv =====
module mer_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_cmd,
  output logic            in_ready,
  input  mer_pkg::dp_sts_t sts,
  output mer_pkg::dp_cmd_t cmd
);
  import mer_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_RY,
    S_SLOPE,
    S_INIT,
    S_SETTLE,
    S_E2_XX,
    S_E2_RY2,
    S_E2_YM1,
    S_E2_RX2,
    S_E2_RXRY,
    S_E2_FIN,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_NONE,
    PH_R1,
    PH_R2
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic   from_step_r, from_step_nxt;
  logic   last_r, last_nxt;
  logic   null_r, null_nxt;
  logic   fin;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    from_step_nxt = from_step_r;
    last_nxt      = last_r;
    null_nxt      = null_r;
    fin           = 1'b0;
    cmd           = '0;
    cmd.op        = OP_NONE;
    cmd.region2   = (phase_r == PH_R2);
    in_ready      = (state_r == S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_START) begin
            cmd.op        = OP_CAPTURE;
            phase_nxt     = PH_R1;
            from_step_nxt = 1'b0;
            state_nxt     = S_SQ_RY;
          end else if (phase_r == PH_NONE) begin
            // advance with no ellipse running gives an empty result
            null_nxt  = 1'b1;
            last_nxt  = 1'b0;
            state_nxt = S_EMIT;
          end else begin
            cmd.op        = OP_STEP;
            from_step_nxt = 1'b1;
            state_nxt     = S_SETTLE;
          end
        end
      end
      S_SQ_RY: begin
        cmd.op    = OP_SQ_RY;
        state_nxt = S_SLOPE;
      end
      S_SLOPE: begin
        cmd.op    = OP_SLOPE;
        state_nxt = S_INIT;
      end
      S_INIT: begin
        cmd.op    = OP_INIT;
        state_nxt = S_SETTLE;
      end
      S_SETTLE: begin
        if (from_step_r) begin
          cmd.op = OP_DEC_UPD;
        end
        null_nxt = 1'b0;
        if (phase_r == PH_R1 && !sts.sx_lt_sy && sts.y_pos) begin
          phase_nxt = PH_R2;
          state_nxt = S_E2_XX;
        end else begin
          fin = !(phase_r == PH_R1 && sts.sx_lt_sy) && !(phase_r == PH_R2 && sts.y_pos);
          if (fin) begin
            phase_nxt = PH_NONE;
          end
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            cmd.last     = fin;
            state_nxt    = S_IDLE;
          end else begin
            last_nxt  = fin;
            state_nxt = S_EMIT;
          end
        end
      end
      S_E2_XX: begin
        cmd.op    = OP_E2_XX;
        state_nxt = S_E2_RY2;
      end
      S_E2_RY2: begin
        cmd.op    = OP_E2_RY2;
        state_nxt = S_E2_YM1;
      end
      S_E2_YM1: begin
        cmd.op    = OP_E2_YM1;
        state_nxt = S_E2_RX2;
      end
      S_E2_RX2: begin
        cmd.op    = OP_E2_RX2;
        state_nxt = S_E2_RXRY;
      end
      S_E2_RXRY: begin
        cmd.op    = OP_E2_RXRY;
        state_nxt = S_E2_FIN;
      end
      S_E2_FIN: begin
        cmd.op = OP_E2_FIN;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          last_nxt  = 1'b0;
          null_nxt  = 1'b0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_null = null_r;
          cmd.last     = last_r;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_NONE;
      from_step_r <= 1'b0;
      last_r      <= 1'b0;
      null_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      from_step_r <= from_step_nxt;
      last_r      <= last_nxt;
      null_r      <= null_nxt;
    end
  end

endmodule

// ===== hdl/mer_dpath.sv =====
module mer_dpath #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mer_pkg::dp_cmd_t              cmd,
  output mer_pkg::dp_sts_t              sts,
  input  logic [COORD_BITS-1:0]         in_center_x,
  input  logic [COORD_BITS-1:0]         in_center_y,
  input  logic [RADIUS_BITS-1:0]        in_radius_x,
  input  logic [RADIUS_BITS-1:0]        in_radius_y,
  input  logic                          in_fill_mode,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic                          out_valid_res,
  output logic                          out_last,
  output logic                          out_is_fill,
  output logic signed [mer_pkg::OUT_W-1:0] out_left_col,
  output logic signed [mer_pkg::OUT_W-1:0] out_right_col,
  output logic signed [mer_pkg::OUT_W-1:0] out_lower_row,
  output logic signed [mer_pkg::OUT_W-1:0] out_upper_row,
  output logic [RADIUS_BITS-1:0]        out_step_x,
  output logic [RADIUS_BITS-1:0]        out_step_y
);
  import mer_pkg::*;

  localparam int R    = RADIUS_BITS;
  localparam int SQ_W = 2 * R;
  localparam int SL_W = 3 * R + 1;
  localparam int P_W  = 4 * R;
  localparam int D_W  = 4 * R + 4;
  localparam int X_W  = R + 1;
  localparam int EW   = COORD_BITS + R + OUT_W;

  // walk state
  logic [COORD_BITS-1:0] ccol_r, ccol_nxt;
  logic [COORD_BITS-1:0] crow_r, crow_nxt;
  logic                  mode_r, mode_nxt;
  logic [X_W-1:0]        x_r, x_nxt;
  logic [R-1:0]          y_r, y_nxt;
  logic [SL_W-1:0]       sx_r, sx_nxt;
  logic [SL_W-1:0]       sy_r, sy_nxt;
  logic [D_W-1:0]        dec_r, dec_nxt;
  logic [D_W-1:0]        acc_r, acc_nxt;
  logic [SQ_W-1:0]       rx2_r, rx2_nxt;
  logic [SQ_W-1:0]       ry2_r, ry2_nxt;
  logic [P_W-1:0]        prod_r, prod_nxt;
  logic                  br_r, br_nxt;

  // result register
  logic                  ovalid_r, ovalid_nxt;
  logic                  res_valid_r, res_valid_nxt;
  logic                  res_last_r, res_last_nxt;
  logic                  res_fill_r, res_fill_nxt;
  logic [OUT_W-1:0]      res_left_r, res_left_nxt;
  logic [OUT_W-1:0]      res_right_r, res_right_nxt;
  logic [OUT_W-1:0]      res_lower_r, res_lower_nxt;
  logic [OUT_W-1:0]      res_upper_r, res_upper_nxt;
  logic [R-1:0]          res_sx_r, res_sx_nxt;
  logic [R-1:0]          res_sy_r, res_sy_nxt;

  logic [SQ_W-1:0]       mul_a, mul_b;
  logic [R-1:0]          y_m1;
  logic [X_W-1:0]        x_p1;
  logic [SL_W-1:0]       sl_ry, sl_rx;
  logic                  dec_neg, dec_pos;
  logic [D_W-1:0]        add_k, add_p, sub_p;
  logic [EW-1:0]         left_w, right_w, lower_w, upper_w;

  assign y_m1    = y_r - 1'b1;
  assign x_p1    = x_r + 1'b1;
  assign sl_ry   = SL_W'({ry2_r, 1'b0});
  assign sl_rx   = SL_W'({rx2_r, 1'b0});
  assign dec_neg = dec_r[D_W-1];
  assign dec_pos = !dec_r[D_W-1] && (|dec_r);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_CAPTURE: begin
        mul_a = SQ_W'(in_radius_x);
        mul_b = SQ_W'(in_radius_x);
      end
      OP_SQ_RY: begin
        mul_a = SQ_W'(y_r);
        mul_b = SQ_W'(y_r);
      end
      OP_SLOPE: begin
        mul_a = rx2_r;
        mul_b = SQ_W'(y_r);
      end
      OP_E2_XX: begin
        mul_a = SQ_W'(x_r);
        mul_b = SQ_W'(x_p1);
      end
      OP_E2_RY2: begin
        mul_a = ry2_r;
        mul_b = prod_r[SQ_W-1:0];
      end
      OP_E2_YM1: begin
        mul_a = SQ_W'(y_m1);
        mul_b = SQ_W'(y_m1);
      end
      OP_E2_RX2: begin
        mul_a = rx2_r;
        mul_b = prod_r[SQ_W-1:0];
      end
      OP_E2_RXRY: begin
        mul_a = rx2_r;
        mul_b = ry2_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // decision update terms: region 1 adds ry2 + sx and drops sy on a diagonal move,
  // region 2 adds rx2 - sy and picks up sx on a diagonal move
  always_comb begin
    add_k = cmd.region2 ? D_W'(rx2_r) : D_W'(ry2_r);
    add_p = (!cmd.region2 || br_r) ? D_W'(sx_r) : '0;
    sub_p = (cmd.region2 || br_r) ? D_W'(sy_r) : '0;
  end

  always_comb begin
    left_w  = EW'(ccol_r) - EW'(x_r);
    right_w = EW'(ccol_r) + EW'(x_r) - EW'(!mode_r);
    lower_w = EW'(crow_r) + EW'(y_r) - EW'(1'b1);
    upper_w = EW'(crow_r) - EW'(y_r);
  end

  always_comb begin
    ccol_nxt = ccol_r;
    crow_nxt = crow_r;
    mode_nxt = mode_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    sx_nxt   = sx_r;
    sy_nxt   = sy_r;
    dec_nxt  = dec_r;
    acc_nxt  = acc_r;
    rx2_nxt  = rx2_r;
    ry2_nxt  = ry2_r;
    br_nxt   = br_r;
    prod_nxt = P_W'(mul_a * mul_b);

    case (cmd.op)
      OP_CAPTURE: begin
        ccol_nxt = in_center_x;
        crow_nxt = in_center_y;
        mode_nxt = in_fill_mode;
        x_nxt    = '0;
        y_nxt    = in_radius_y;
        sx_nxt   = '0;
      end
      OP_SQ_RY: begin
        rx2_nxt = prod_r[SQ_W-1:0];
      end
      OP_SLOPE: begin
        ry2_nxt = prod_r[SQ_W-1:0];
      end
      OP_INIT: begin
        sy_nxt  = {prod_r[SL_W-2:0], 1'b0};
        dec_nxt = D_W'(ry2_r) - D_W'(prod_r) + D_W'(rx2_r >> 2);
      end
      OP_STEP: begin
        if (!cmd.region2) begin
          x_nxt  = x_p1;
          sx_nxt = sx_r + sl_ry;
          if (dec_neg) begin
            br_nxt = 1'b0;
          end else begin
            y_nxt  = y_m1;
            sy_nxt = sy_r - sl_rx;
            br_nxt = 1'b1;
          end
        end else begin
          y_nxt  = y_m1;
          sy_nxt = sy_r - sl_rx;
          if (dec_pos) begin
            br_nxt = 1'b0;
          end else begin
            x_nxt  = x_p1;
            sx_nxt = sx_r + sl_ry;
            br_nxt = 1'b1;
          end
        end
      end
      OP_DEC_UPD: begin
        dec_nxt = dec_r + add_k + add_p - sub_p;
      end
      OP_E2_YM1: begin
        acc_nxt = D_W'(prod_r) + D_W'(ry2_r >> 2);
      end
      OP_E2_RXRY: begin
        acc_nxt = acc_r + D_W'(prod_r);
      end
      OP_E2_FIN: begin
        dec_nxt = acc_r - D_W'(prod_r);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ovalid_nxt    = ovalid_r;
    res_valid_nxt = res_valid_r;
    res_last_nxt  = res_last_r;
    res_fill_nxt  = res_fill_r;
    res_left_nxt  = res_left_r;
    res_right_nxt = res_right_r;
    res_lower_nxt = res_lower_r;
    res_upper_nxt = res_upper_r;
    res_sx_nxt    = res_sx_r;
    res_sy_nxt    = res_sy_r;
    if (cmd.out_load) begin
      ovalid_nxt = 1'b1;
      if (cmd.out_null) begin
        res_valid_nxt = 1'b0;
        res_last_nxt  = 1'b0;
        res_fill_nxt  = 1'b0;
        res_left_nxt  = '0;
        res_right_nxt = '0;
        res_lower_nxt = '0;
        res_upper_nxt = '0;
        res_sx_nxt    = '0;
        res_sy_nxt    = '0;
      end else begin
        res_valid_nxt = 1'b1;
        res_last_nxt  = cmd.last;
        res_fill_nxt  = mode_r;
        res_left_nxt  = left_w[OUT_W-1:0];
        res_right_nxt = right_w[OUT_W-1:0];
        res_lower_nxt = lower_w[OUT_W-1:0];
        res_upper_nxt = upper_w[OUT_W-1:0];
        res_sx_nxt    = x_r[R-1:0];
        res_sy_nxt    = y_r;
      end
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ccol_r      <= ccol_nxt;
    crow_r      <= crow_nxt;
    mode_r      <= mode_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    sx_r        <= sx_nxt;
    sy_r        <= sy_nxt;
    dec_r       <= dec_nxt;
    acc_r       <= acc_nxt;
    rx2_r       <= rx2_nxt;
    ry2_r       <= ry2_nxt;
    prod_r      <= prod_nxt;
    br_r        <= br_nxt;
    res_valid_r <= res_valid_nxt;
    res_last_r  <= res_last_nxt;
    res_fill_r  <= res_fill_nxt;
    res_left_r  <= res_left_nxt;
    res_right_r <= res_right_nxt;
    res_lower_r <= res_lower_nxt;
    res_upper_r <= res_upper_nxt;
    res_sx_r    <= res_sx_nxt;
    res_sy_r    <= res_sy_nxt;
  end

  assign sts.sx_lt_sy = (sx_r < sy_r);
  assign sts.y_pos    = |y_r;
  assign sts.out_free = !ovalid_r || out_ready;

  assign out_valid     = ovalid_r;
  assign out_valid_res = res_valid_r;
  assign out_last      = res_last_r;
  assign out_is_fill   = res_fill_r;
  assign out_left_col  = $signed(res_left_r);
  assign out_right_col = $signed(res_right_r);
  assign out_lower_row = $signed(res_lower_r);
  assign out_upper_row = $signed(res_upper_r);
  assign out_step_x    = res_sx_r;
  assign out_step_y    = res_sy_r;

endmodule

// ===== hdl/midpoint_ellipse_rasterizer_top.sv =====
// channel   role    handshake     payload
// in_ch     sink    valid/ready   cmd, center_x, center_y, radius_x, radius_y, fill_mode
// out_ch    source  valid/ready   valid_res, last, is_fill, left/right_col, lower/upper_row,
//                                 step_x, step_y
//
// advance: step update, then decision update and region check
// entering region 2 adds the E2_XX to E2_RXRY products on the one shared multiplier, then E2_FIN
// start: three squares/products through the multiplier, setup, region check
// advance with no ellipse running gives a result with valid_res low
// a finished result waits in the output register while the next transaction is accepted
// reset is synchronous, active low, and clears the sequencer and the output valid flag
module midpoint_ellipse_rasterizer_top #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 10
) (
  input logic       clk,
  input logic       rst_n,
  mer_in_if.sink    in_ch,
  mer_out_if.source out_ch
);
  import mer_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;
  logic    in_ready;

  mer_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ready),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  assign in_ch.ready = in_ready;

  mer_dpath #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (dp_cmd),
    .sts           (dp_sts),
    .in_center_x   (in_ch.center_x),
    .in_center_y   (in_ch.center_y),
    .in_radius_x   (in_ch.radius_x),
    .in_radius_y   (in_ch.radius_y),
    .in_fill_mode  (in_ch.fill_mode),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_valid_res (out_ch.valid_res),
    .out_last      (out_ch.last),
    .out_is_fill   (out_ch.is_fill),
    .out_left_col  (out_ch.left_col),
    .out_right_col (out_ch.right_col),
    .out_lower_row (out_ch.lower_row),
    .out_upper_row (out_ch.upper_row),
    .out_step_x    (out_ch.step_x),
    .out_step_y    (out_ch.step_y)
  );

`ifndef ASSERT_OFF
  a_one_transaction: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while a transaction is still in work");

  a_last_on_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last |-> out_ch.step_y == '0)
    else $error("final step of an ellipse off the horizontal axis");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.out_load |-> dp_sts.out_free)
    else $error("result register overwritten before it was taken");

  a_region2_order: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.op == OP_E2_FIN |-> $past(dp_cmd.op) == OP_E2_RXRY)
    else $error("region 2 decision finished out of sequence");
`endif

endmodule
